@@ rtl/undo_redo_history_stack_top_assert.svh @@
// Assertion macros used by the top RTL file of the history stack.
`ifndef UNDO_REDO_HISTORY_STACK_TOP_ASSERT_SVH
`define UNDO_REDO_HISTORY_STACK_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define URH_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("assertion failed: %m");
`define URH_ASSERT_NEXT(lbl, cond, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error("assertion failed: %m");
`else
`define URH_ASSERT(lbl, prop)
`define URH_ASSERT_NEXT(lbl, cond, prop)
`endif

`endif

@@ rtl/urh_pkg.sv @@
package urh_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int WORD_W    = 64;
    localparam int POS_OUT_W = 4;

    typedef enum logic [2:0] {
        MODE_PUSH     = 3'd0,
        MODE_INCLUDE  = 3'd1,
        MODE_BACKWARD = 3'd2,
        MODE_FORWARD  = 3'd3,
        MODE_FIRST    = 3'd4,
        MODE_CLEAR    = 3'd5
    } t_mode;

    typedef struct packed {
        t_mode               mode;
        logic [WORD_W-1:0]   entry_data;
    } t_req;

    typedef struct packed {
        logic [WORD_W-1:0]    read_data;
        logic                 read_valid;
        logic                 can_back;
        logic                 can_forward;
        logic [POS_OUT_W-1:0] current_pos;
    } t_rsp;

endpackage

@@ rtl/undo_redo_history_stack_top.sv @@
// Bounded undo/redo history: one request is taken at a time.
// After acceptance the request moves to S_READ; its result is registered once the output register is free.
// No new request is taken while in S_READ, the state that covers the registered read of the history memory.
// A waiting result does not block the next request; only a second result would.
// Reset is synchronous and active low: the history is empty, nothing is redoable.
`include "undo_redo_history_stack_top_assert.svh"

module undo_redo_history_stack_top import urh_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_stall,
    output t_rsp o_rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int PW = AW + 1;
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic signed [PW-1:0] POS_NONE = '1;
    localparam logic signed [PW-1:0] POS_ZERO = '0;
    localparam logic signed [PW-1:0] POS_ONE  = PW'(1);
    localparam logic signed [PW-1:0] POS_MAX  = PW'(DEPTH - 1);
    localparam logic [CW-1:0]        REDO_MAX = CW'(DEPTH);
    localparam logic [AW-1:0]        BASE_MAX = AW'(DEPTH - 1);
    localparam logic [AW:0]          SLOT_LIM = (AW + 1)'(DEPTH);

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    t_state                r_state;
    logic signed [PW-1:0]  r_pos;
    logic signed [PW-1:0]  r_top;
    logic [CW-1:0]         r_redo;
    logic [AW-1:0]         r_base;
    logic                  r_use_word;
    logic [WORD_W-1:0]     r_word;
    logic                  r_rd_valid;
    logic                  r_back;
    logic                  r_fwd;
    logic [POS_OUT_W-1:0]  r_cpos;
    logic                  r_out_valid;
    t_rsp                  r_rsp;

    logic signed [PW-1:0]  n_pos;
    logic signed [PW-1:0]  n_top;
    logic [CW-1:0]         n_redo;
    logic [AW-1:0]         n_base;
    logic                  n_wr;
    logic [AW:0]           slot_sum;
    logic [AW-1:0]         slot;
    logic                  accept;
    logic                  load_out;
    logic [WORD_W-1:0]     mem_rdata;

    assign accept   = i_valid && (r_state == S_IDLE);
    assign load_out = (r_state == S_READ) && (!r_out_valid || !i_stall);

    always_comb begin
        n_pos  = r_pos;
        n_top  = r_top;
        n_redo = r_redo;
        n_base = r_base;
        n_wr   = 1'b0;
        unique case (i_req.mode)
            MODE_PUSH, MODE_INCLUDE: begin
                if (r_pos == POS_MAX) begin
                    n_base = (r_base == BASE_MAX) ? '0 : r_base + AW'(1);
                    n_pos  = POS_MAX;
                end else begin
                    n_pos = r_pos + POS_ONE;
                end
                if (n_pos > r_top) begin
                    n_top = n_pos;
                end
                if (i_req.mode == MODE_INCLUDE) begin
                    n_redo = '0;
                end
                n_wr = 1'b1;
            end
            MODE_BACKWARD: begin
                if (r_pos <= POS_ZERO) begin
                    n_pos = POS_ZERO;
                end else begin
                    n_pos = r_pos - POS_ONE;
                    if (r_redo < REDO_MAX) begin
                        n_redo = r_redo + CW'(1);
                    end
                end
            end
            MODE_FORWARD: begin
                if (r_redo != '0) begin
                    if (r_pos >= r_top) begin
                        n_pos  = r_top;
                        n_redo = '0;
                    end else begin
                        n_pos  = r_pos + POS_ONE;
                        n_redo = r_redo - CW'(1);
                    end
                end
            end
            MODE_FIRST: begin
                n_pos = POS_ZERO;
                n_top = POS_ZERO;
                n_wr  = 1'b1;
            end
            MODE_CLEAR: begin
                n_pos  = POS_NONE;
                n_top  = POS_NONE;
                n_redo = '0;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        slot_sum = {1'b0, n_base} + {1'b0, n_pos[AW-1:0]};
        if (slot_sum >= SLOT_LIM) begin
            slot = AW'(slot_sum - SLOT_LIM);
        end else begin
            slot = slot_sum[AW-1:0];
        end
    end

    urh_store #(
        .DEPTH(DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_wr_en (accept && n_wr),
        .i_rd_en (accept && !n_wr),
        .i_addr  (slot),
        .i_wdata (i_req.entry_data),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= POS_NONE;
            r_top       <= POS_NONE;
            r_redo      <= '0;
            r_base      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_state    <= S_READ;
                r_pos      <= n_pos;
                r_top      <= n_top;
                r_redo     <= n_redo;
                r_base     <= n_base;
                r_use_word <= n_wr;
                r_word     <= i_req.entry_data;
                r_rd_valid <= (n_pos >= POS_ZERO) && (n_pos <= n_top);
                r_back     <= n_pos > POS_ZERO;
                r_fwd      <= n_redo != '0;
                r_cpos     <= (n_pos > POS_ZERO) ? POS_OUT_W'(n_pos[AW-1:0]) : '0;
            end
            if (load_out) begin
                r_state               <= S_IDLE;
                r_out_valid           <= 1'b1;
                r_rsp.read_data       <= !r_rd_valid ? '0 :
                                         (r_use_word ? r_word : mem_rdata);
                r_rsp.read_valid      <= r_rd_valid;
                r_rsp.can_back        <= r_back;
                r_rsp.can_forward     <= r_fwd;
                r_rsp.current_pos     <= r_cpos;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_rsp   = r_rsp;

    `URH_ASSERT(a_redo_bounded, r_redo <= REDO_MAX)
    `URH_ASSERT(a_base_bounded, r_base <= BASE_MAX)
    `URH_ASSERT(a_pos_within_top, (r_pos > POS_ZERO) |-> (r_pos <= r_top))
    `URH_ASSERT_NEXT(a_accept_busy, i_valid && !o_stall, o_stall)

endmodule

@@ rtl/urh_store.sv @@
module urh_store import urh_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WORD_W-1:0]        i_wdata,
    output logic [WORD_W-1:0]        o_rdata
);

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_rd_en) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ tb/undo_redo_history_stack_top_tb.sv @@
module undo_redo_history_stack_top_tb import urh_pkg::*; ();

    localparam int    CYCLE_LIMIT = 200000;
    localparam t_mode MODE_SPARE6 = t_mode'(3'd6);
    localparam t_mode MODE_SPARE7 = t_mode'(3'd7);

    class undo_history_scoreboard;
        logic [WORD_W-1:0] slot_word [DEPTH_DEF];
        bit                slot_seen [DEPTH_DEF];
        int                cur_pos;
        int                top_pos;
        int                redo_left;
        int                base;
        t_rsp              expected_views [$];
        int                errors;

        function new();
            cur_pos   = -1;
            top_pos   = -1;
            redo_left = 0;
            base      = 0;
            errors    = 0;
            foreach (slot_word[i]) begin
                slot_word[i] = '0;
                slot_seen[i] = 1'b0;
            end
        endfunction

        function int slot_of(int logical);
            return (base + logical) % DEPTH_DEF;
        endfunction

        // A push after a backward on an empty history would expose a slot
        // that has never been written.
        function bit push_exposes_blank();
            return cur_pos == 0 && top_pos == -1 && !slot_seen[slot_of(0)];
        endfunction

        function void store_above(logic [WORD_W-1:0] word);
            cur_pos++;
            if (cur_pos >= DEPTH_DEF) begin
                base    = (base + 1) % DEPTH_DEF;
                cur_pos = DEPTH_DEF - 1;
            end
            slot_word[slot_of(cur_pos)] = word;
            slot_seen[slot_of(cur_pos)] = 1'b1;
            if (cur_pos > top_pos) begin
                top_pos = cur_pos;
            end
        endfunction

        function void note_request(t_req req);
            t_rsp view;
            case (req.mode)
                MODE_PUSH: begin
                    store_above(req.entry_data);
                end
                MODE_INCLUDE: begin
                    store_above(req.entry_data);
                    redo_left = 0;
                end
                MODE_BACKWARD: begin
                    cur_pos--;
                    if (cur_pos < 0) begin
                        cur_pos = 0;
                    end else if (redo_left < DEPTH_DEF) begin
                        redo_left++;
                    end
                end
                MODE_FORWARD: begin
                    if (redo_left > 0) begin
                        cur_pos++;
                        if (cur_pos > top_pos) begin
                            cur_pos   = top_pos;
                            redo_left = 0;
                        end else begin
                            redo_left--;
                        end
                    end
                end
                MODE_FIRST: begin
                    cur_pos = 0;
                    top_pos = 0;
                    slot_word[slot_of(0)] = req.entry_data;
                    slot_seen[slot_of(0)] = 1'b1;
                end
                MODE_CLEAR: begin
                    cur_pos   = -1;
                    top_pos   = -1;
                    redo_left = 0;
                end
                default: begin
                end
            endcase
            view.read_valid  = (cur_pos >= 0) && (cur_pos <= top_pos);
            view.read_data   = view.read_valid ? slot_word[slot_of(cur_pos)] : '0;
            view.can_back    = cur_pos > 0;
            view.can_forward = redo_left > 0;
            view.current_pos = (cur_pos > 0) ? POS_OUT_W'(cur_pos) : '0;
            expected_views.push_back(view);
        endfunction

        function int pending();
            return expected_views.size();
        endfunction

        task report(string what);
            errors++;
            $display("MISMATCH: %s", what);
        endtask

        task check_result(t_rsp got);
            t_rsp want;
            if (expected_views.size() == 0) begin
                report("result arrived with no request outstanding");
                return;
            end
            want = expected_views.pop_front();
            if (got.read_data !== want.read_data) begin
                report($sformatf("read_data %h, expected %h", got.read_data, want.read_data));
            end
            if (got.read_valid !== want.read_valid) begin
                report($sformatf("read_valid %b, expected %b", got.read_valid,
                                 want.read_valid));
            end
            if (got.can_back !== want.can_back) begin
                report($sformatf("can_back %b, expected %b", got.can_back, want.can_back));
            end
            if (got.can_forward !== want.can_forward) begin
                report($sformatf("can_forward %b, expected %b", got.can_forward,
                                 want.can_forward));
            end
            if (got.current_pos !== want.current_pos) begin
                report($sformatf("current_pos %0d, expected %0d", got.current_pos,
                                 want.current_pos));
            end
        endtask
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    t_req i_req   = '0;
    logic o_stall;
    logic o_valid;
    t_rsp o_rsp;

    undo_history_scoreboard history_sb = new();

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int rsp_hold_req  = 0;
    int hold_left     = 0;
    int cycles        = 0;

    undo_redo_history_stack_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_rsp   (o_rsp)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                history_sb.check_result(o_rsp);
            end
            if (rsp_hold_req > 0) begin
                hold_left    = rsp_hold_req;
                rsp_hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    task automatic send_request(input t_req req);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= req;
        do @(posedge i_clk); while (o_stall);
        history_sb.note_request(req);
    endtask

    task automatic offer(input t_mode mode, input logic [WORD_W-1:0] word);
        t_req req;
        if ((mode == MODE_PUSH || mode == MODE_INCLUDE) && history_sb.push_exposes_blank()) begin
            mode = MODE_FIRST;
        end
        req.mode       = mode;
        req.entry_data = word;
        send_request(req);
    endtask

    function automatic logic [WORD_W-1:0] random_word();
        int pick;
        pick = $urandom_range(7);
        if (pick == 0) begin
            return '0;
        end else if (pick == 1) begin
            return '1;
        end
        return {$urandom, $urandom};
    endfunction

    function automatic t_mode random_mode();
        int pick;
        pick = $urandom_range(99);
        if (pick < 30) return MODE_PUSH;
        if (pick < 42) return MODE_INCLUDE;
        if (pick < 62) return MODE_BACKWARD;
        if (pick < 82) return MODE_FORWARD;
        if (pick < 88) return MODE_FIRST;
        if (pick < 93) return MODE_CLEAR;
        if (pick < 97) return MODE_SPARE6;
        return MODE_SPARE7;
    endfunction

    task automatic run_random(input int count);
        int    kind;
        int    len;
        int    sent;
        t_mode mode;
        sent = 0;
        while (sent < count) begin
            kind = $urandom_range(3);
            len  = $urandom_range(5, 24);
            for (int k = 0; k < len && sent < count; k++) begin
                case (kind)
                    0: begin
                        if ($urandom_range(4) == 0) begin
                            mode = MODE_INCLUDE;
                        end else begin
                            mode = MODE_PUSH;
                        end
                    end
                    1: begin
                        if ($urandom_range(1) != 0) begin
                            mode = MODE_BACKWARD;
                        end else begin
                            mode = MODE_FORWARD;
                        end
                    end
                    default: mode = random_mode();
                endcase
                offer(mode, random_word());
                sent++;
            end
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (history_sb.pending() != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 38;
        recv_idle_pct = 85;
        offer(MODE_SPARE7, '1);
        offer(MODE_BACKWARD, '0);
        offer(MODE_FORWARD, '0);
        offer(MODE_CLEAR, '0);
        offer(MODE_FIRST, '1);
        offer(MODE_PUSH, '0);
        offer(MODE_INCLUDE, 64'hAAAA_AAAA_AAAA_AAAA);
        offer(MODE_PUSH, 64'h5555_5555_5555_5555);
        offer(MODE_BACKWARD, '0);
        offer(MODE_BACKWARD, '0);
        offer(MODE_FORWARD, '0);
        offer(MODE_PUSH, 64'h8000_0000_0000_0001);
        offer(MODE_FORWARD, '0);
        offer(MODE_FORWARD, '0);
        offer(MODE_SPARE6, 64'h0123_4567_89AB_CDEF);
        offer(MODE_BACKWARD, '0);
        offer(MODE_BACKWARD, '0);
        offer(MODE_BACKWARD, '0);
        offer(MODE_BACKWARD, '0);
        offer(MODE_INCLUDE, 64'hFEDC_BA98_7654_3210);
        offer(MODE_FORWARD, '0);
        offer(MODE_CLEAR, '1);
        offer(MODE_FORWARD, '0);
        offer(MODE_FIRST, 64'h7FFF_FFFF_FFFF_FFFE);
        run_random(260);
        drain();

        send_idle_pct = 85;
        recv_idle_pct = 38;
        run_random(280);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(100);
        rsp_hold_req = 80;
        run_random(60);
        drain();
        run_random(120);

        i_valid <= 1'b0;
        drain();
        repeat (6) @(posedge i_clk);
        if (history_sb.errors == 0 && history_sb.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/urh_pkg.sv
rtl/urh_store.sv
rtl/undo_redo_history_stack_top.sv
tb/undo_redo_history_stack_top_tb.sv
